[hdl/risc_instruction_execute_unit_defines.svh]
// ----------------------------------------------------------------------------
// RISC execute unit assertion macros
// Shared concurrent assertion forms, sampled on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RISC_INSTRUCTION_EXECUTE_UNIT_DEFINES_SVH
`define RISC_INSTRUCTION_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define RIEU_ASSERT_IMP(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication.
`define RIEU_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

[hdl/rieu_pkg.sv]
// ----------------------------------------------------------------------------
// RISC execute unit package
// Widths, opcodes, status codes and the structs shared by the unit's files.
// ----------------------------------------------------------------------------
package rieu_pkg;

   localparam int WORD_W     = 32;
   localparam int REG_COUNT  = 32;
   localparam int RF_ADDR_W  = 5;
   localparam int DATA_BASE  = 1024;
   localparam int DATA_WORDS = 1024;
   localparam int DM_ADDR_W  = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

   localparam logic [3:0] OP_ADD  = 4'd0;
   localparam logic [3:0] OP_SUB  = 4'd1;
   localparam logic [3:0] OP_MULI = 4'd2;
   localparam logic [3:0] OP_ADDI = 4'd3;
   localparam logic [3:0] OP_BNE  = 4'd4;
   localparam logic [3:0] OP_ANDI = 4'd5;
   localparam logic [3:0] OP_ORI  = 4'd6;
   localparam logic [3:0] OP_J    = 4'd7;
   localparam logic [3:0] OP_SLL  = 4'd8;
   localparam logic [3:0] OP_SRL  = 4'd9;
   localparam logic [3:0] OP_LW   = 4'd10;
   localparam logic [3:0] OP_SW   = 4'd11;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_RANGE  = 2'd1;
   localparam logic [1:0] STATUS_BAD_OP = 2'd2;

   typedef struct packed {
      logic [31:0] instruction_word;
   } req_type;

   typedef struct packed {
      logic [31:0]        next_pc;
      logic               branch_taken;
      logic               reg_written;
      logic [4:0]         dest_reg;
      logic [31:0]        write_value;
      logic               mem_written;
      logic signed [31:0] mem_address;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [WORD_W-1:0]    next_pc;
      logic                 taken;
      logic                 reg_wr;
      logic [RF_ADDR_W-1:0] dest_reg;
      logic [WORD_W-1:0]    value;
      logic                 load_ok;
      logic                 store_ok;
      logic [WORD_W-1:0]    mem_addr;
      logic [DM_ADDR_W-1:0] mem_index;
      logic [WORD_W-1:0]    store_data;
      logic [1:0]           status;
   } exec_type;

   typedef struct packed {
      logic                 en;
      logic [RF_ADDR_W-1:0] addr;
      logic [WORD_W-1:0]    data;
   } rf_wr_type;

   typedef struct packed {
      logic                 en;
      logic                 we;
      logic [DM_ADDR_W-1:0] addr;
      logic [WORD_W-1:0]    wdata;
   } dm_req_type;

endpackage

[hdl/rieu_chan_if.sv]
// ----------------------------------------------------------------------------
// RISC execute unit channel
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface rieu_chan_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

[hdl/risc_instruction_execute_unit.sv]
// ----------------------------------------------------------------------------
// RISC instruction execute unit
// Executes one 32-bit instruction per beat in order, with a register file,
// program counter and data memory, and reports each instruction's effects.
//
//   Channel    Dir   Payload            Beat
//   req_chan   in    instruction_word   one instruction
//   rsp_chan   out   rieu_pkg::rsp_type one result per instruction
//
// An instruction is accepted in every cycle unless the result stage stalls;
// it passes one register stage for operand reads and one for the result.
// After reset the data memory is swept to zero, and no instruction is
// accepted during the sweep.
// A stalled result holds; one further instruction is taken into the operand
// stage meanwhile, and operands are forwarded from the result stage.
// ----------------------------------------------------------------------------
`include "risc_instruction_execute_unit_defines.svh"

module risc_instruction_execute_unit (
   input logic         clock,
   input logic         reset,
   rieu_chan_if.sink   req_chan,
   rieu_chan_if.source rsp_chan
);
   import rieu_pkg::*;

   logic                 accept;
   logic                 mv;
   logic                 dm_busy;
   logic [WORD_W-1:0]    in_word;
   logic [3:0]           in_op;
   logic [RF_ADDR_W-1:0] in_x_addr;
   logic [RF_ADDR_W-1:0] in_b_addr;

   logic                 s1_valid_ff;
   logic [WORD_W-1:0]    s1_word_ff;
   logic [RF_ADDR_W-1:0] s1_x_addr_ff;
   logic [RF_ADDR_W-1:0] s1_b_addr_ff;
   logic                 ovr_x_v_ff;
   logic                 ovr_b_v_ff;
   logic [WORD_W-1:0]    ovr_x_d_ff;
   logic [WORD_W-1:0]    ovr_b_d_ff;

   logic                 s2_valid_ff;
   logic                 s2_fresh_ff;
   exec_type             s2_exe_ff;
   logic [WORD_W-1:0]    pc_ff;

   logic [WORD_W-1:0]    rf_rd_x;
   logic [WORD_W-1:0]    rf_rd_b;
   logic [WORD_W-1:0]    dm_rd_data;
   logic [WORD_W-1:0]    wb_value;
   logic                 pend;
   logic [WORD_W-1:0]    opnd_x;
   logic [WORD_W-1:0]    opnd_b;
   rf_wr_type            rf_wr;
   dm_req_type           dm_req;
   exec_type             exe;
   rsp_type              rsp;

   assign in_word   = req_chan.payload.instruction_word;
   assign in_op     = in_word[31:28];
   assign in_x_addr = ((in_op == OP_BNE) || (in_op == OP_SW)) ? in_word[27:23] : in_word[17:13];
   assign in_b_addr = in_word[22:18];

   assign mv             = s1_valid_ff && (!s2_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !dm_busy && (!s1_valid_ff || mv);
   assign accept         = req_chan.valid && req_chan.ready;

   assign wb_value = s2_exe_ff.load_ok ? dm_rd_data : s2_exe_ff.value;
   assign pend     = s2_fresh_ff && s2_exe_ff.reg_wr;

   assign rf_wr.en   = pend;
   assign rf_wr.addr = s2_exe_ff.dest_reg;
   assign rf_wr.data = wb_value;

   assign opnd_x = (pend && (s2_exe_ff.dest_reg == s1_x_addr_ff)) ? wb_value :
                   (ovr_x_v_ff ? ovr_x_d_ff : rf_rd_x);
   assign opnd_b = (pend && (s2_exe_ff.dest_reg == s1_b_addr_ff)) ? wb_value :
                   (ovr_b_v_ff ? ovr_b_d_ff : rf_rd_b);

   assign dm_req.en    = mv && (exe.load_ok || exe.store_ok);
   assign dm_req.we    = exe.store_ok;
   assign dm_req.addr  = exe.mem_index;
   assign dm_req.wdata = exe.store_data;

   rieu_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .wr        (rf_wr),
      .rd_en     (accept),
      .rd_addr_x (in_x_addr),
      .rd_addr_b (in_b_addr),
      .rd_data_x (rf_rd_x),
      .rd_data_b (rf_rd_b)
   );

   rieu_data_mem u_data_mem (
      .clock   (clock),
      .reset   (reset),
      .req     (dm_req),
      .rd_data (dm_rd_data),
      .busy    (dm_busy)
   );

   rieu_alu u_alu (
      .instr  (s1_word_ff),
      .pc     (pc_ff),
      .opnd_x (opnd_x),
      .opnd_b (opnd_b),
      .exe    (exe)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         ovr_x_v_ff  <= 1'b0;
         ovr_b_v_ff  <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (mv) begin
            s1_valid_ff <= 1'b0;
         end
         if (accept) begin
            ovr_x_v_ff <= rf_wr.en && (rf_wr.addr == in_x_addr);
            ovr_b_v_ff <= rf_wr.en && (rf_wr.addr == in_b_addr);
         end else begin
            if (rf_wr.en && (rf_wr.addr == s1_x_addr_ff)) begin
               ovr_x_v_ff <= 1'b1;
            end
            if (rf_wr.en && (rf_wr.addr == s1_b_addr_ff)) begin
               ovr_b_v_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_ff   <= in_word;
         s1_x_addr_ff <= in_x_addr;
         s1_b_addr_ff <= in_b_addr;
      end
      if (accept || (rf_wr.en && (rf_wr.addr == s1_x_addr_ff))) begin
         ovr_x_d_ff <= rf_wr.data;
      end
      if (accept || (rf_wr.en && (rf_wr.addr == s1_b_addr_ff))) begin
         ovr_b_d_ff <= rf_wr.data;
      end
      if (mv) begin
         s2_exe_ff <= exe;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s2_fresh_ff <= 1'b0;
         pc_ff       <= '0;
      end else begin
         s2_fresh_ff <= mv;
         if (mv) begin
            s2_valid_ff <= 1'b1;
            pc_ff       <= exe.next_pc;
         end else if (rsp_chan.ready) begin
            s2_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      rsp.next_pc      = s2_exe_ff.next_pc;
      rsp.branch_taken = s2_exe_ff.taken;
      rsp.reg_written  = s2_exe_ff.reg_wr;
      rsp.dest_reg     = s2_exe_ff.dest_reg;
      rsp.write_value  = wb_value;
      rsp.mem_written  = s2_exe_ff.store_ok;
      rsp.mem_address  = $signed(s2_exe_ff.mem_addr);
      rsp.status       = s2_exe_ff.status;
   end

   assign rsp_chan.valid   = s2_valid_ff;
   assign rsp_chan.payload = rsp;

   `RIEU_ASSERT_IMP(a_sweep_blocks_pipe, dm_busy, !s1_valid_ff && !s2_valid_ff && !req_chan.ready, "instruction in flight during memory sweep")
   `RIEU_ASSERT_IMP(a_writeback_has_result, s2_fresh_ff, s2_valid_ff, "writeback without a held result")
   `RIEU_ASSERT_IMP(a_no_r0_write, rf_wr.en, rf_wr.addr != '0, "register write to R0")
   `RIEU_ASSERT_NEXT(a_pc_only_on_commit, !mv, $stable(pc_ff), "program counter moved without a commit")

endmodule

[hdl/rieu_regfile.sv]
// ----------------------------------------------------------------------------
// RISC execute unit register file
// Register array with one write port, two registered read ports and a valid
// bit per entry so that unwritten registers, and R0, read as zero.
// ----------------------------------------------------------------------------
module rieu_regfile (
   input  logic                             clock,
   input  logic                             reset,
   input  rieu_pkg::rf_wr_type              wr,
   input  logic                             rd_en,
   input  logic [rieu_pkg::RF_ADDR_W-1:0]   rd_addr_x,
   input  logic [rieu_pkg::RF_ADDR_W-1:0]   rd_addr_b,
   output logic [rieu_pkg::WORD_W-1:0]      rd_data_x,
   output logic [rieu_pkg::WORD_W-1:0]      rd_data_b
);
   import rieu_pkg::*;

   logic [WORD_W-1:0]    mem [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [WORD_W-1:0]    rd_x_ff;
   logic [WORD_W-1:0]    rd_b_ff;
   logic                 rd_vx_ff;
   logic                 rd_vb_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_x_ff <= mem[rd_addr_x];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_vx_ff <= 1'b0;
         rd_vb_ff <= 1'b0;
      end else begin
         if (wr.en && (wr.addr != '0)) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vx_ff <= valid_ff[rd_addr_x];
            rd_vb_ff <= valid_ff[rd_addr_b];
         end
      end
   end

   assign rd_data_x = rd_vx_ff ? rd_x_ff : '0;
   assign rd_data_b = rd_vb_ff ? rd_b_ff : '0;

endmodule

[hdl/rieu_data_mem.sv]
// ----------------------------------------------------------------------------
// RISC execute unit data memory
// Single-port word memory with a registered read and a clearing sweep that
// zeroes every word after reset.
// ----------------------------------------------------------------------------
module rieu_data_mem (
   input  logic                        clock,
   input  logic                        reset,
   input  rieu_pkg::dm_req_type        req,
   output logic [rieu_pkg::WORD_W-1:0] rd_data,
   output logic                        busy
);
   import rieu_pkg::*;

   localparam logic [DM_ADDR_W-1:0] LAST_INDEX = DM_ADDR_W'(DATA_WORDS - 1);

   logic [WORD_W-1:0]    mem [DATA_WORDS];
   logic [WORD_W-1:0]    rd_ff;
   logic [DM_ADDR_W-1:0] clr_cnt_ff;
   logic                 busy_ff;

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (req.en && req.we) begin
         mem[req.addr] <= req.wdata;
      end
      if (!busy_ff && req.en && !req.we) begin
         rd_ff <= mem[req.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + DM_ADDR_W'(1);
         if (clr_cnt_ff == LAST_INDEX) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign rd_data = rd_ff;
   assign busy    = busy_ff;

endmodule

[hdl/rieu_alu.sv]
// ----------------------------------------------------------------------------
// RISC execute unit ALU
// Decodes one instruction and computes its result, next program counter,
// effective address and status from the forwarded operands.
// ----------------------------------------------------------------------------
module rieu_alu (
   input  logic [rieu_pkg::WORD_W-1:0] instr,
   input  logic [rieu_pkg::WORD_W-1:0] pc,
   input  logic [rieu_pkg::WORD_W-1:0] opnd_x,
   input  logic [rieu_pkg::WORD_W-1:0] opnd_b,
   output rieu_pkg::exec_type          exe
);
   import rieu_pkg::*;

   logic [3:0]           op;
   logic [RF_ADDR_W-1:0] r1;
   logic [WORD_W-1:0]    imm;
   logic [WORD_W-1:0]    pc1;
   logic                 big_shift;
   logic [WORD_W-1:0]    maddr;
   logic [WORD_W:0]      offset;
   logic                 in_range;
   logic [WORD_W-1:0]    product;
   logic                 writes;
   logic                 has_dest;

   assign op        = instr[31:28];
   assign r1        = instr[27:23];
   assign imm       = {{14{instr[17]}}, instr[17:0]};
   assign pc1       = pc + 32'd1;
   assign big_shift = |instr[12:5];
   assign maddr     = opnd_b + imm;
   assign offset    = {1'b0, maddr} - 33'(DATA_BASE);
   assign in_range  = !offset[WORD_W] && (offset[WORD_W-1:0] < 32'(DATA_WORDS));
   assign product   = opnd_b * imm;

   always_comb begin
      exe            = '0;
      exe.next_pc    = pc1;
      exe.mem_index  = offset[DM_ADDR_W-1:0];
      exe.store_data = opnd_x;
      exe.status     = STATUS_OK;
      writes         = 1'b0;
      has_dest       = 1'b1;
      unique case (op)
         OP_ADD: begin
            exe.value = opnd_b + opnd_x;
            writes    = 1'b1;
         end
         OP_SUB: begin
            exe.value = opnd_b - opnd_x;
            writes    = 1'b1;
         end
         OP_MULI: begin
            exe.value = product;
            writes    = 1'b1;
         end
         OP_ADDI: begin
            exe.value = opnd_b + imm;
            writes    = 1'b1;
         end
         OP_BNE: begin
            has_dest = 1'b0;
            if (opnd_x != opnd_b) begin
               exe.next_pc = pc1 + imm;
               exe.taken   = 1'b1;
            end
         end
         OP_ANDI: begin
            exe.value = opnd_b & imm;
            writes    = 1'b1;
         end
         OP_ORI: begin
            exe.value = opnd_b | imm;
            writes    = 1'b1;
         end
         OP_J: begin
            has_dest    = 1'b0;
            exe.next_pc = {pc1[31:28], instr[27:0]};
            exe.taken   = 1'b1;
         end
         OP_SLL: begin
            exe.value = big_shift ? '0 : (opnd_b << instr[4:0]);
            writes    = 1'b1;
         end
         OP_SRL: begin
            exe.value = big_shift ? '0 : (opnd_b >> instr[4:0]);
            writes    = 1'b1;
         end
         OP_LW: begin
            exe.mem_addr = maddr;
            if (in_range) begin
               exe.load_ok = 1'b1;
               writes      = 1'b1;
            end else begin
               exe.status = STATUS_RANGE;
            end
         end
         OP_SW: begin
            has_dest     = 1'b0;
            exe.mem_addr = maddr;
            if (in_range) begin
               exe.store_ok = 1'b1;
            end else begin
               exe.status = STATUS_RANGE;
            end
         end
         default: begin
            has_dest   = 1'b0;
            exe.status = STATUS_BAD_OP;
         end
      endcase
      exe.dest_reg = has_dest ? r1 : '0;
      exe.reg_wr   = writes && (r1 != '0);
   end

endmodule

[verif/risc_instruction_execute_unit_test.sv]
// ----------------------------------------------------------------------------
// RISC instruction execute unit testbench
// Sends directed and random instruction streams through the request channel,
// predicts each result from a local model of the register file, program
// counter and data memory, and checks every result beat field by field.
// Both channels idle in random bursts, and the result side holds off once
// for a long stretch so that the unit fills up and stalls its input.
// ----------------------------------------------------------------------------
module risc_instruction_execute_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   import rieu_pkg::*;

   localparam logic [3:0] OP_FIRST_UNUSED = 4'hC;
   localparam logic [3:0] OP_LAST_UNUSED  = 4'hF;
   localparam int RANDOM_ITEMS = 525;
   localparam int TAIL_ITEMS   = 80;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rieu_chan_if #(.payload_type(req_type)) req_chan ();
   rieu_chan_if #(.payload_type(rsp_type)) rsp_chan ();

   risc_instruction_execute_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [31:0] arch_regs [REG_COUNT];
   logic [31:0] arch_pc;
   logic [31:0] data_mem [DATA_WORDS];

   logic [31:0] pending_instructions [$];
   rsp_type     expected_results [$];
   rsp_type     predicted;

   int  total_items = 0;
   int  issued_count = 0;
   int  results_seen = 0;
   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   logic stall_hold = 1'b0;
   logic tail_phase;

   assign tail_phase = (issued_count + TAIL_ITEMS >= total_items);

   always #1 clock = ~clock;

   function automatic logic [31:0] encode(input logic [3:0] op, input logic [4:0] rd,
                                          input logic [4:0] rs, input logic [17:0] low);
      return {op, rd, rs, low};
   endfunction

   function automatic rsp_type execute_instruction(input logic [31:0] word);
      logic [3:0]  opcode;
      logic [4:0]  ra, rb, rc;
      logic [12:0] shamt;
      logic [31:0] a_val, b_val, c_val, imm, pc_inc, eff_addr, offset;
      logic        in_range, has_dest, writes;
      rsp_type     r;
      opcode   = word[31:28];
      ra       = word[27:23];
      rb       = word[22:18];
      rc       = word[17:13];
      shamt    = word[12:0];
      imm      = {{14{word[17]}}, word[17:0]};
      a_val    = arch_regs[ra];
      b_val    = arch_regs[rb];
      c_val    = arch_regs[rc];
      pc_inc   = arch_pc + 32'd1;
      eff_addr = b_val + imm;
      offset   = eff_addr - 32'(DATA_BASE);
      in_range = (eff_addr >= 32'(DATA_BASE)) && (offset < 32'(DATA_WORDS));
      r = '0;
      r.next_pc = pc_inc;
      case (opcode)
         OP_ADD:  r.write_value = b_val + c_val;
         OP_SUB:  r.write_value = b_val - c_val;
         OP_MULI: r.write_value = b_val * imm;
         OP_ADDI: r.write_value = b_val + imm;
         OP_ANDI: r.write_value = b_val & imm;
         OP_ORI:  r.write_value = b_val | imm;
         OP_SLL:  r.write_value = (shamt < 13'd32) ? b_val << shamt : 32'd0;
         OP_SRL:  r.write_value = (shamt < 13'd32) ? b_val >> shamt : 32'd0;
         OP_BNE: begin
            if (a_val != b_val) begin
               r.next_pc = pc_inc + imm;
               r.branch_taken = 1'b1;
            end
         end
         OP_J: begin
            r.next_pc = {pc_inc[31:28], word[27:0]};
            r.branch_taken = 1'b1;
         end
         OP_LW: begin
            r.mem_address = eff_addr;
            if (in_range) begin
               r.write_value = data_mem[offset[DM_ADDR_W-1:0]];
            end else begin
               r.status = STATUS_RANGE;
            end
         end
         OP_SW: begin
            r.mem_address = eff_addr;
            if (in_range) begin
               data_mem[offset[DM_ADDR_W-1:0]] = a_val;
               r.mem_written = 1'b1;
            end else begin
               r.status = STATUS_RANGE;
            end
         end
         default: r.status = STATUS_BAD_OP;
      endcase
      has_dest = (opcode <= OP_LW) && (opcode != OP_BNE) && (opcode != OP_J);
      writes = has_dest && ((opcode != OP_LW) || in_range);
      if (has_dest) begin
         r.dest_reg = ra;
      end
      if (writes && ra != 5'd0) begin
         arch_regs[ra] = r.write_value;
         r.reg_written = 1'b1;
      end
      arch_pc = r.next_pc;
      return r;
   endfunction

   function automatic logic [31:0] random_instruction();
      logic [31:0] word;
      logic [3:0]  opcode;
      word = $urandom;
      if ($urandom_range(0, 99) < 4) begin
         opcode = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      end else begin
         opcode = 4'($urandom_range(OP_ADD, OP_SW));
      end
      word[31:28] = opcode;
      case (opcode)
         OP_LW, OP_SW: begin
            case ($urandom_range(0, 3))
               0: ;
               1: begin
                  word[22:18] = 5'd0;
                  word[17:0] = 18'(DATA_BASE - 4 + $urandom_range(0, DATA_WORDS + 7));
               end
               default: begin
                  word[22:18] = 5'd0;
                  word[17:0] = 18'(DATA_BASE + $urandom_range(0, 15));
               end
            endcase
         end
         OP_SLL, OP_SRL: begin
            if ($urandom_range(0, 2) != 0) begin
               word[12:0] = 13'($urandom_range(0, 40));
            end
         end
         OP_BNE: begin
            if ($urandom_range(0, 2) == 0) begin
               word[22:18] = word[27:23];
            end
         end
         default: ;
      endcase
      return word;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            issued_count++;
            expected_results.push_back(execute_instruction(pending_instructions.pop_front()));
         end
         if (!(req_chan.valid && !req_chan.ready)) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (!tail_phase && $urandom_range(0, 11) == 0) begin
               send_gap = $urandom_range(1, 19);
            end
            if (send_gap == 0 && pending_instructions.size() > 0) begin
               req_chan.valid <= 1'b1;
               req_chan.payload <= req_type'(pending_instructions[0]);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $display("%0t: result beat with nothing expected, actual next_pc %h",
                        $time, rsp_chan.payload.next_pc);
               mismatch_count++;
            end else begin
               predicted = expected_results.pop_front();
               check_field("next_pc", predicted.next_pc, rsp_chan.payload.next_pc);
               check_field("branch_taken", 32'(predicted.branch_taken),
                           32'(rsp_chan.payload.branch_taken));
               check_field("reg_written", 32'(predicted.reg_written),
                           32'(rsp_chan.payload.reg_written));
               check_field("dest_reg", 32'(predicted.dest_reg),
                           32'(rsp_chan.payload.dest_reg));
               check_field("write_value", predicted.write_value, rsp_chan.payload.write_value);
               check_field("mem_written", 32'(predicted.mem_written),
                           32'(rsp_chan.payload.mem_written));
               check_field("mem_address", predicted.mem_address, rsp_chan.payload.mem_address);
               check_field("status", 32'(predicted.status), 32'(rsp_chan.payload.status));
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
         end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(1, 19);
         end
         rsp_chan.ready <= (recv_gap == 0) && !stall_hold;
      end
   end

   // The result side stops taking beats for a long stretch partway through.
   initial begin
      wait (results_seen >= 150);
      @(posedge clock);
      stall_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      stall_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** risc_instruction_execute_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      arch_pc = '0;
      foreach (arch_regs[i]) arch_regs[i] = '0;
      foreach (data_mem[i]) data_mem[i] = '0;

      pending_instructions.push_back(encode(OP_ADDI, 5'd1, 5'd0, 18'h1FFFF));
      pending_instructions.push_back(encode(OP_ADDI, 5'd2, 5'd0, 18'h20000));
      pending_instructions.push_back(encode(OP_ADDI, 5'd3, 5'd0, 18'h3FFFF));
      pending_instructions.push_back(encode(OP_ADD, 5'd4, 5'd3, {5'd3, 13'd0}));
      pending_instructions.push_back(encode(OP_SUB, 5'd5, 5'd0, {5'd3, 13'd0}));
      pending_instructions.push_back(encode(OP_SUB, 5'd6, 5'd2, {5'd1, 13'd0}));
      pending_instructions.push_back(encode(OP_MULI, 5'd7, 5'd3, 18'h20000));
      pending_instructions.push_back(encode(OP_MULI, 5'd8, 5'd1, 18'h1FFFF));
      pending_instructions.push_back(encode(OP_ANDI, 5'd9, 5'd3, 18'h20000));
      pending_instructions.push_back(encode(OP_ORI, 5'd10, 5'd0, 18'h15555));
      pending_instructions.push_back(encode(OP_SLL, 5'd11, 5'd3, {5'd0, 13'd31}));
      pending_instructions.push_back(encode(OP_SLL, 5'd12, 5'd3, {5'd0, 13'd32}));
      pending_instructions.push_back(encode(OP_SRL, 5'd13, 5'd3, {5'd0, 13'd1}));
      pending_instructions.push_back(encode(OP_SRL, 5'd14, 5'd3, {5'h1F, 13'h1FFF}));
      pending_instructions.push_back(encode(OP_ADDI, 5'd0, 5'd3, 18'd5));
      pending_instructions.push_back(encode(OP_SW, 5'd3, 5'd0, 18'(DATA_BASE)));
      pending_instructions.push_back(encode(OP_SW, 5'd4, 5'd0,
                                            18'(DATA_BASE + DATA_WORDS - 1)));
      pending_instructions.push_back(encode(OP_SW, 5'd1, 5'd0, 18'(DATA_BASE - 1)));
      pending_instructions.push_back(encode(OP_SW, 5'd1, 5'd3, 18'd0));
      pending_instructions.push_back(encode(OP_LW, 5'd15, 5'd0, 18'(DATA_BASE)));
      pending_instructions.push_back(encode(OP_LW, 5'd16, 5'd0,
                                            18'(DATA_BASE + DATA_WORDS - 1)));
      pending_instructions.push_back(encode(OP_LW, 5'd17, 5'd0,
                                            18'(DATA_BASE + DATA_WORDS)));
      pending_instructions.push_back(encode(OP_LW, 5'd0, 5'd0, 18'(DATA_BASE)));
      pending_instructions.push_back(encode(OP_BNE, 5'd0, 5'd0, 18'h3FFF0));
      pending_instructions.push_back(encode(OP_BNE, 5'd1, 5'd2, 18'h3FFF0));
      pending_instructions.push_back({OP_J, 28'hFFFFFFF});
      pending_instructions.push_back({OP_FIRST_UNUSED, 28'h1234567});
      pending_instructions.push_back({OP_LAST_UNUSED, 28'hFFFFFFF});
      repeat (RANDOM_ITEMS) pending_instructions.push_back(random_instruction());
      total_items = pending_instructions.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_instructions.size() != 0 || expected_results.size() != 0);
      repeat (8) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("** risc_instruction_execute_unit: PASSED **");
      end else begin
         $display("** risc_instruction_execute_unit: FAILED **");
      end
      $finish;
   end

endmodule
